// ----- design/bdqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_pkg: shared types and constants of the bounded deque
// Capacity, field widths, operation and status codes, channel items and the
// control bundle that the top level broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package bdqs_pkg;

   // Number of entries the deque holds.
   localparam int CAPACITY = 16;
   // Width of a front-relative position and of the entry count.
   localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int DATA_W = 32;

   // Operation codes (codes 5 to 7 do nothing).
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
      logic                     found;
      logic [POS_W-1:0]         position;
      logic [CNT_W-1:0]         entry_count;
      logic                     queue_empty;
   } rsp_type;

   // Control broadcast to every cell in the row.
   typedef struct packed {
      logic              load;
      logic              push_front;
      logic              push_back;
      logic              pop_front;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  count;
   } cell_ctl_type;

endpackage

// ----- design/bdqs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_cell: one entry of the deque
// Holds the entry at a fixed front-relative position. Shifts toward the back
// on a front push, toward the front on a front pop, loads the value when it
// is the tail slot of a back push, and flags a match for a search.
// ----------------------------------------------------------------------------
module bdqs_cell (
   input  logic                         clock,
   input  bdqs_pkg::cell_ctl_type       ctl,
   input  logic [bdqs_pkg::CNT_W-1:0]   idx,
   input  logic [bdqs_pkg::DATA_W-1:0]  left_data,
   input  logic [bdqs_pkg::DATA_W-1:0]  right_data,
   output logic [bdqs_pkg::DATA_W-1:0]  data,
   output logic                         hit
);

   logic [bdqs_pkg::DATA_W-1:0] data_ff;
   logic [bdqs_pkg::DATA_W-1:0] data_in;
   logic                        hit_ff;
   logic                        hit_in;

   // Pick the next entry from the neighbors or the pushed value
   always_comb begin
      data_in = data_ff;
      if (ctl.push_front) begin
         data_in = left_data;
      end else if (ctl.pop_front) begin
         data_in = right_data;
      end else if (ctl.push_back && (idx == ctl.count)) begin
         data_in = ctl.value;
      end
   end

   // Compare only entries that are held
   assign hit_in = (data_ff == ctl.value) && (idx < ctl.count);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.load) begin
         hit_ff <= hit_in;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// ----- design/bounded_deque_with_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top: bounded deque of 32-bit integers with search
// Push and pop at either end, and search for the first entry equal to a value.
// ----------------------------------------------------------------------------
// The deque is a row of CAPACITY cells, cell i holding the entry i places from
// the front; a front push or pop shifts the whole row one cell at the accepting edge.
// Each item is handled in order: at the accepting edge the cells update and
// all compare against the value in parallel, and then in the S_DONE state the
// first match is encoded and the result is loaded into the output register. The
// next item is taken right after that, even while the result still waits to
// be taken; an item waits longer only while the output register is occupied
// when its result is ready. No clearing pass follows reset.
module bounded_deque_with_search_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdqs_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdqs_pkg::rsp_type rsp_item
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DONE = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   logic [bdqs_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [2:0]                      op_ff;
   logic [1:0]                      status_ff, status_in;
   logic [bdqs_pkg::DATA_W-1:0]     popped_ff, popped_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bdqs_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            accept;
   logic                            is_full;
   logic                            is_empty;
   logic                            is_push;
   logic                            is_pop;
   logic                            out_free;
   bdqs_pkg::cell_ctl_type          ctl;

   logic [bdqs_pkg::DATA_W-1:0]     cell_data [bdqs_pkg::CAPACITY];
   logic [bdqs_pkg::CAPACITY-1:0]   hit_vec;
   logic [bdqs_pkg::CAPACITY-1:0]   first_hit;
   logic [bdqs_pkg::POS_W-1:0]      position;
   logic [bdqs_pkg::POS_W-1:0]      tail_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == bdqs_pkg::CNT_W'(bdqs_pkg::CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign is_push   = (req_item.opcode == bdqs_pkg::OP_PUSH_FRONT)
                   || (req_item.opcode == bdqs_pkg::OP_PUSH_BACK);
   assign is_pop    = (req_item.opcode == bdqs_pkg::OP_POP_FRONT)
                   || (req_item.opcode == bdqs_pkg::OP_POP_BACK);

   // Broadcast the operation to the row
   always_comb begin
      ctl.load       = accept;
      ctl.push_front = accept && !is_full && (req_item.opcode == bdqs_pkg::OP_PUSH_FRONT);
      ctl.push_back  = accept && !is_full && (req_item.opcode == bdqs_pkg::OP_PUSH_BACK);
      ctl.pop_front  = accept && !is_empty && (req_item.opcode == bdqs_pkg::OP_POP_FRONT);
      ctl.value      = req_item.value;
      ctl.count      = count_ff;
   end

   // Row of cells: front neighbor feeds a front push, back neighbor a front pop
   for (genvar i = 0; i < bdqs_pkg::CAPACITY; i++) begin : g_cell
      logic [bdqs_pkg::DATA_W-1:0] left_d;
      logic [bdqs_pkg::DATA_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = req_item.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == bdqs_pkg::CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end
      bdqs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (bdqs_pkg::CNT_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .hit        (hit_vec[i])
      );
   end

   // Status, popped value and new count at the accepting edge
   assign tail_idx = bdqs_pkg::POS_W'(count_ff - 1'b1);

   always_comb begin
      status_in = bdqs_pkg::STATUS_OK;
      popped_in = '0;
      count_in  = count_ff;
      case (req_item.opcode)
         bdqs_pkg::OP_PUSH_FRONT, bdqs_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = bdqs_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         bdqs_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status_in = bdqs_pkg::STATUS_EMPTY;
            end else begin
               popped_in = cell_data[0];
               count_in  = count_ff - 1'b1;
            end
         end
         bdqs_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               status_in = bdqs_pkg::STATUS_EMPTY;
            end else begin
               popped_in = cell_data[tail_idx];
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Isolate the frontmost match and encode its position
   assign first_hit = hit_vec & (~hit_vec + 1'b1);

   always_comb begin
      position = '0;
      for (int i = 0; i < bdqs_pkg::CAPACITY; i++) begin
         if (first_hit[i]) begin
            position = position | bdqs_pkg::POS_W'(i);
         end
      end
   end

   // Assemble the result
   always_comb begin
      rsp_in.status       = status_ff;
      rsp_in.popped_value = popped_ff;
      rsp_in.found        = (op_ff == bdqs_pkg::OP_SEARCH) && (|hit_vec);
      rsp_in.position     = (op_ff == bdqs_pkg::OP_SEARCH) ? position : '0;
      rsp_in.entry_count  = count_ff;
      rsp_in.queue_empty  = (count_ff == '0);
   end

   // Sequence: take the item, then hand the result to the output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the per-item fields and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_item.opcode;
         status_ff <= status_in;
         popped_ff <= popped_in;
      end
      if ((state_ff == S_DONE) && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bdqs_pkg::CNT_W'(bdqs_pkg::CAPACITY))
      else $error("entry count above capacity");

   // An accepted item is always followed by the result cycle
   a_accept_done: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DONE))
      else $error("accepted item not followed by result cycle");

   // A push on a full deque leaves it full
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && is_full && is_push) |=> is_full)
      else $error("push on full deque changed the count");

   // A pop on an empty deque leaves it empty
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (accept && is_empty && is_pop) |=> is_empty)
      else $error("pop on empty deque changed the count");

   // A match is only reported with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.found) |-> (rsp_item.status == bdqs_pkg::STATUS_OK))
      else $error("match reported with a non-ok status");

endmodule
